[hdl/lsfp_pkg.sv]
// Shared constants and types for the scan frame parser.
// No dependencies; every other file in hdl/ imports this package.
package lsfp_pkg;

    localparam int PACKETS_PER_FRAME   = 60;
    localparam int PACKET_BYTES        = 42;
    localparam int READINGS_PER_PACKET = 6;

    localparam logic [7:0] SYNC_FIRST  = 8'hFA;
    localparam logic [7:0] SYNC_SECOND = 8'hA0;
    localparam logic [8:0] LAST_ANGLE  = 9'd359;

    // Byte offsets inside a packet and inside a reading
    localparam logic [5:0] OFS_SYNC0   = 6'd0;
    localparam logic [5:0] OFS_SYNC1   = 6'd1;
    localparam logic [5:0] OFS_SPEED_L = 6'd2;
    localparam logic [5:0] OFS_SPEED_H = 6'd3;
    localparam logic [2:0] RD_RANGE_H  = 3'd3;
    localparam logic [2:0] RD_LAST     = 3'd5;

    // Reciprocal of ten for a 16-bit dividend: q = (x * 52429) >> 19
    localparam logic [15:0] DIV10_MULT  = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_IN_FRAME    = 2'd2
    } sync_phase_t;

endpackage

[hdl/lsfp_div10.sv]
// Divide a 16-bit speed word by ten with a reciprocal multiply.
// Depends on lsfp_pkg for the multiplier constant and shift.
module lsfp_div10 (
    input  logic [15:0] dividend,
    output logic [12:0] quotient
);
    import lsfp_pkg::*;

    logic [31:0] product;

    // Exact for every 16-bit input: the reciprocal error stays below one tenth
    assign product  = 32'(dividend) * 32'(DIV10_MULT);
    assign quotient = product[DIV10_SHIFT +: 13];

endmodule

[hdl/lidar_scan_frame_parser.sv]
// Scan frame parser top level: sync hunt, packet counting, reading output.
// Depends on lsfp_pkg and lsfp_div10.
//
//  channel | ports                                   | direction | transfer
//  --------+-----------------------------------------+-----------+----------------------
//  input   | s_valid s_ready s_rx_byte               | in        | one received byte
//  result  | m_valid m_ready m_angle m_range_mm      | out       | one reading
//          | m_intensity m_rpm m_last_of_scan        |           |
//
// Cycles: one byte per cycle unless stalled. Each byte is decoded in the cycle it
// is accepted and a reading, when one completes, sits in the output register the
// next cycle. The only storage between the two sides is that single output
// register, so s_ready is high whenever it is empty or being drained in the same
// cycle. Reset (aresetn low, synchronous) returns to hunting the first sync byte.
// A stall on the result side holds the reading and stops input only while it waits.
module lidar_scan_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_angle,
    output logic [15:0] m_range_mm,
    output logic [15:0] m_intensity,
    output logic [12:0] m_rpm,
    output logic        m_last_of_scan
);
    import lsfp_pkg::*;

    // Parser state
    sync_phase_t  phase_reg, phase_next;
    logic [5:0]   pkt_num_reg, pkt_num_next;
    logic [5:0]   byte_idx_reg, byte_idx_next;
    logic         pkt_ok_reg, pkt_ok_next;
    logic [12:0]  rpm_reg, rpm_next;        // speed word already divided by ten
    logic [23:0]  held_reg, held_next;      // low speed byte, or reading bytes 0..2
    logic [2:0]   rd_ofs_reg, rd_ofs_next;  // byte offset inside the current reading
    logic [3:0]   rd_num_reg, rd_num_next;  // reading number inside the packet

    // Output register
    logic         m_valid_reg, m_valid_next;
    logic [8:0]   angle_reg, angle_next;
    logic [15:0]  range_reg, range_next;
    logic [15:0]  inten_reg, inten_next;
    logic [12:0]  out_rpm_reg, out_rpm_next;
    logic         last_reg, last_next;

    logic         accept;
    logic         emit;
    logic [6:0]   byte_idx_inc;
    logic [6:0]   pkt_num_inc;
    logic [8:0]   reading_idx;
    logic [12:0]  speed_div10;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    lsfp_div10 u_div10 (
        .dividend ({s_rx_byte, held_reg[7:0]}),
        .quotient (speed_div10)
    );

    // Reading number over the whole frame; sets angle and the end-of-scan flag
    assign reading_idx  = 9'(pkt_num_reg) * 9'(READINGS_PER_PACKET) + 9'(rd_num_reg);
    assign byte_idx_inc = 7'(byte_idx_reg) + 7'd1;
    assign pkt_num_inc  = 7'(pkt_num_reg) + 7'd1;

    always_comb begin
        phase_next    = phase_reg;
        pkt_num_next  = pkt_num_reg;
        byte_idx_next = byte_idx_reg;
        pkt_ok_next   = pkt_ok_reg;
        rpm_next      = rpm_reg;
        held_next     = held_reg;
        rd_ofs_next   = rd_ofs_reg;
        rd_num_next   = rd_num_reg;
        emit          = 1'b0;

        if (accept) begin
            case (phase_reg)
                PH_HUNT_SECOND: begin
                    // A wrong second byte drops back without rechecking it as 0xFA
                    if (s_rx_byte == SYNC_SECOND) begin
                        phase_next    = PH_IN_FRAME;
                        pkt_num_next  = '0;
                        byte_idx_next = 6'd2;
                        pkt_ok_next   = 1'b1;
                    end else begin
                        phase_next = PH_HUNT_FIRST;
                    end
                end
                PH_IN_FRAME: begin
                    case (byte_idx_reg)
                        OFS_SYNC0: begin
                            pkt_ok_next = (s_rx_byte == SYNC_FIRST);
                        end
                        OFS_SYNC1: begin
                            if (s_rx_byte != SYNC_SECOND + {2'b00, pkt_num_reg})
                                pkt_ok_next = 1'b0;
                        end
                        OFS_SPEED_L: begin
                            held_next = {16'h0000, s_rx_byte};
                        end
                        OFS_SPEED_H: begin
                            rpm_next    = speed_div10;
                            rd_ofs_next = '0;
                            rd_num_next = '0;
                        end
                        default: begin
                            // Reading bytes: latch 0..2, emit on 3, skip reserved
                            case (rd_ofs_reg)
                                3'd0: held_next[7:0]   = s_rx_byte;
                                3'd1: held_next[15:8]  = s_rx_byte;
                                3'd2: held_next[23:16] = s_rx_byte;
                                default: ;
                            endcase
                            if (rd_ofs_reg == RD_RANGE_H && pkt_ok_reg &&
                                rd_num_reg < 4'(READINGS_PER_PACKET))
                                emit = 1'b1;
                            if (rd_ofs_reg == RD_LAST) begin
                                rd_ofs_next = '0;
                                rd_num_next = rd_num_reg + 4'd1;
                            end else begin
                                rd_ofs_next = rd_ofs_reg + 3'd1;
                            end
                        end
                    endcase

                    // Advance through the packet, then through the frame
                    if (byte_idx_inc >= 7'(PACKET_BYTES)) begin
                        byte_idx_next = '0;
                        if (pkt_num_inc >= 7'(PACKETS_PER_FRAME)) begin
                            pkt_num_next = '0;
                            phase_next   = PH_HUNT_FIRST;
                        end else begin
                            pkt_num_next = pkt_num_inc[5:0];
                        end
                    end else begin
                        byte_idx_next = byte_idx_inc[5:0];
                    end
                end
                default: begin
                    // Hunting the first sync byte; the unused code behaves the same
                    phase_next = (s_rx_byte == SYNC_FIRST) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
                end
            endcase
        end
    end

    // Load a new reading, or drain the register once it is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        angle_next   = angle_reg;
        range_next   = range_reg;
        inten_next   = inten_reg;
        out_rpm_next = out_rpm_reg;
        last_next    = last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            angle_next   = LAST_ANGLE - reading_idx;
            range_next   = {s_rx_byte, held_reg[23:16]};
            inten_next   = held_reg[15:0];
            out_rpm_next = rpm_reg;
            last_next    = (reading_idx == LAST_ANGLE);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT_FIRST;
            pkt_num_reg  <= '0;
            byte_idx_reg <= '0;
            pkt_ok_reg   <= 1'b0;
            rpm_reg      <= '0;
            held_reg     <= '0;
            rd_ofs_reg   <= '0;
            rd_num_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pkt_num_reg  <= pkt_num_next;
            byte_idx_reg <= byte_idx_next;
            pkt_ok_reg   <= pkt_ok_next;
            rpm_reg      <= rpm_next;
            held_reg     <= held_next;
            rd_ofs_reg   <= rd_ofs_next;
            rd_num_reg   <= rd_num_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        angle_reg   <= angle_next;
        range_reg   <= range_next;
        inten_reg   <= inten_next;
        out_rpm_reg <= out_rpm_next;
        last_reg    <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_angle        = angle_reg;
    assign m_range_mm     = range_reg;
    assign m_intensity    = inten_reg;
    assign m_rpm          = out_rpm_reg;
    assign m_last_of_scan = last_reg;

endmodule
